// ===== rtl/aldk_pkg.sv =====
// Shared types and constants of the ADC ladder key debouncer.
`default_nettype none

package aldk_pkg;

  localparam int TableDepth = 16;
  localparam int SampleBits = 12;

  localparam int AddrW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW        = $clog2(TableDepth + 1);
  localparam int EntryCountW = 5;
  localparam int ThreshW     = 8;
  localparam int WindowW     = 8;
  localparam int CodeW       = 10;
  localparam int KeyW        = CodeW + 1;
  localparam int MaskW       = 16;
  localparam int IndexW      = 4;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 8;

  // Bit CodeW set means no key.
  localparam logic [KeyW-1:0] KeyNone = {1'b1, {CodeW{1'b0}}};

  localparam logic [ThreshW-1:0] DebounceReset = 8'd1;
  localparam logic [WindowW-1:0] WindowReset   = 8'd10;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdWrite  = 1'b1;

  localparam logic ModeKeys = 1'b0;
  localparam logic ModeDial = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEntryCount,
    CfgChannelMode,
    CfgDebounce,
    CfgWindow
  } cfg_idx_e;

  typedef struct packed {
    logic                  cmd;
    logic [SampleBits-1:0] sample;
    logic [MaskW-1:0]      key_mask;
    logic [IndexW-1:0]     entry_index;
    logic [SampleBits-1:0] entry_level;
    logic [CodeW-1:0]      entry_code;
    logic [MaskW-1:0]      entry_mask;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]      key_code;
    logic                  pressed;
    logic [SampleBits-1:0] adc_value;
    logic                  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [SampleBits-1:0] level;
    logic [CodeW-1:0]      code;
    logic [MaskW-1:0]      mask;
  } table_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic             start;
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             chk_dec;
    logic             chk_mask;
    logic             update;
    logic             load_ev0;
    logic             load_ev1;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CntW-1:0] searched;
    logic            mode;
    logic [1:0]      n_ev;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/aldk_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none

module aldk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aldk_ctrl.sv =====
// Sequencer: table walks for decode and mask check, update, event emission.
`default_nettype none

module aldk_ctrl
  import aldk_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_cmd_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDec,
    StDecEnd,
    StMask,
    StMaskEnd,
    StUpdate,
    StEmit0,
    StEmit1
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] idx_q;
  logic             chk_dec_q;
  logic             chk_mask_q;
  logic             last_idx;
  logic             accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign last_idx   = ((CntW'(idx_q) + CntW'(1)) == stat_i.searched);

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_addr  = idx_q;
    cmd_o.chk_dec  = chk_dec_q;
    cmd_o.chk_mask = chk_mask_q;
    cmd_o.start    = accept;
    cmd_o.wr_en    = accept && (in_cmd_i == CmdWrite);
    cmd_o.rd_en    = (state_q == StDec) || (state_q == StMask);
    cmd_o.update   = (state_q == StUpdate);
    cmd_o.load_ev0 = (state_q == StEmit0) && (stat_i.n_ev != 2'd0) && stat_i.out_free;
    cmd_o.load_ev1 = (state_q == StEmit1) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      idx_q      <= '0;
      chk_dec_q  <= 1'b0;
      chk_mask_q <= 1'b0;
    end else begin
      chk_dec_q  <= (state_q == StDec);
      chk_mask_q <= (state_q == StMask);
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (accept && (in_cmd_i == CmdSample)) begin
            state_q <= (stat_i.searched == '0) ? StUpdate : StDec;
          end
        end
        StDec: begin
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= StDecEnd;
          end else begin
            idx_q <= idx_q + AddrW'(1);
          end
        end
        StDecEnd: begin
          // the mask check only applies to ordinary keys
          state_q <= (stat_i.mode == ModeKeys) ? StMask : StUpdate;
        end
        StMask: begin
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= StMaskEnd;
          end else begin
            idx_q <= idx_q + AddrW'(1);
          end
        end
        StMaskEnd: state_q <= StUpdate;
        StUpdate:  state_q <= StEmit0;
        StEmit0: begin
          if (stat_i.n_ev == 2'd0) begin
            state_q <= StIdle;
          end else if (stat_i.out_free) begin
            state_q <= (stat_i.n_ev == 2'd1) ? StIdle : StEmit1;
          end
        end
        StEmit1: begin
          if (stat_i.out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aldk_dpath.sv =====
// Datapath: key table, config registers, decode and debounce state, output register.
`default_nettype none

module aldk_dpath
  import aldk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire in_item_t            in_data_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire dp_cmd_t             cmd_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o
);

  localparam int LvlXW = SampleBits + 1;

  // configuration
  logic [EntryCountW-1:0] entry_count_q;
  logic                   mode_q;
  logic [ThreshW-1:0]     thr_q;
  logic [WindowW-1:0]     window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      mode_q        <= ModeKeys;
      thr_q         <= DebounceReset;
      window_q      <= WindowReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgEntryCount:  entry_count_q <= cfg_data_i[EntryCountW-1:0];
        CfgChannelMode: mode_q        <= cfg_data_i[0];
        CfgDebounce:    thr_q         <= cfg_data_i[ThreshW-1:0];
        CfgWindow:      window_q      <= cfg_data_i[WindowW-1:0];
        default: ;
      endcase
    end
  end

  // key table
  table_entry_t                      wr_ent;
  logic [$bits(table_entry_t)-1:0]   rd_raw;
  table_entry_t                      rd_ent;
  logic                              wr_ok;

  assign wr_ent.level = in_data_i.entry_level;
  assign wr_ent.code  = in_data_i.entry_code;
  assign wr_ent.mask  = in_data_i.entry_mask;
  assign wr_ok        = cmd_i.wr_en && (int'(in_data_i.entry_index) < TableDepth);
  assign rd_ent       = table_entry_t'(rd_raw);

  aldk_ram #(
    .Width($bits(table_entry_t)),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(AddrW'(in_data_i.entry_index)),
    .wdata_i(wr_ent),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rd_raw)
  );

  // latched sample beat
  logic [SampleBits-1:0] samp_q;
  logic [MaskW-1:0]      kmask_q;

  // decode and debounce state
  logic [KeyW-1:0]    key_q, key_d;
  logic               found_q, found_d;
  logic               masked_q, masked_d;
  logic [KeyW-1:0]    prev_q, prev_d;
  logic [KeyW-1:0]    held_q, held_d;
  logic [KeyW-1:0]    dial_q, dial_d;
  logic [ThreshW-1:0] cnt_q, cnt_d;
  logic [1:0]         n_ev_q, n_ev_d;
  out_item_t          ev0_q, ev0_d, ev1_q, ev1_d;

  // window match
  logic [LvlXW-1:0] lvl_x, w_x, lo_x, hi_x, s_x;
  logic             in_window;
  logic [KeyW-1:0]  mask_target;
  logic             mask_hit;
  logic [ThreshW-1:0] cnt_base;
  out_item_t        ev_press, ev_rel_held, ev_rel_key;

  assign lvl_x     = LvlXW'(rd_ent.level);
  assign w_x       = LvlXW'(window_q);
  assign lo_x      = (lvl_x > w_x) ? (lvl_x - w_x) : '0;
  assign hi_x      = lvl_x + w_x;
  assign s_x       = LvlXW'(samp_q);
  assign in_window = (lo_x <= s_x) && (s_x <= hi_x);

  // a none key checks the held key instead; a none held key never matches
  assign mask_target = key_q[CodeW] ? held_q : key_q;
  assign mask_hit    = ({1'b0, rd_ent.code} == mask_target) && ((rd_ent.mask & kmask_q) != '0);

  assign cnt_base = (prev_q != key_q) ? '0 : cnt_q;

  always_comb begin
    ev_press.key_code    = key_q[CodeW-1:0];
    ev_press.pressed     = 1'b1;
    ev_press.adc_value   = samp_q;
    ev_press.last_of_run = 1'b0;
    ev_rel_held.key_code    = held_q[CodeW-1:0];
    ev_rel_held.pressed     = 1'b0;
    ev_rel_held.adc_value   = '0;
    ev_rel_held.last_of_run = 1'b0;
    ev_rel_key.key_code     = key_q[CodeW-1:0];
    ev_rel_key.pressed      = 1'b0;
    ev_rel_key.adc_value    = '0;
    ev_rel_key.last_of_run  = 1'b1;
  end

  always_comb begin
    key_d    = key_q;
    found_d  = found_q;
    masked_d = masked_q;
    prev_d   = prev_q;
    held_d   = held_q;
    dial_d   = dial_q;
    cnt_d    = cnt_q;
    n_ev_d   = n_ev_q;
    ev0_d    = ev0_q;
    ev1_d    = ev1_q;

    if (cmd_i.start) begin
      key_d    = KeyNone;
      found_d  = 1'b0;
      masked_d = 1'b0;
    end

    // first matching slot wins
    if (cmd_i.chk_dec && !found_q && in_window) begin
      found_d = 1'b1;
      key_d   = {1'b0, rd_ent.code};
    end

    if (cmd_i.chk_mask && mask_hit) begin
      masked_d = 1'b1;
    end

    if (cmd_i.update) begin
      n_ev_d = 2'd0;
      if (mode_q == ModeKeys) begin
        if (!masked_q) begin
          prev_d = key_q;
          if (key_q != held_q) begin
            if (cnt_base < thr_q) begin
              cnt_d = cnt_base + ThreshW'(1);
            end else begin
              cnt_d  = '0;
              held_d = key_q;
              if (!key_q[CodeW]) begin
                if (!held_q[CodeW]) begin
                  ev0_d  = ev_rel_held;
                  ev1_d  = ev_press;
                  ev1_d.last_of_run = 1'b1;
                  n_ev_d = 2'd2;
                end else begin
                  ev0_d  = ev_press;
                  ev0_d.last_of_run = 1'b1;
                  n_ev_d = 2'd1;
                end
              end else begin
                ev0_d  = ev_rel_held;
                ev0_d.last_of_run = 1'b1;
                n_ev_d = 2'd1;
              end
            end
          end else begin
            cnt_d = '0;
          end
        end
      end else begin
        if (!key_q[CodeW] && (key_q != dial_q)) begin
          if (cnt_q < thr_q) begin
            cnt_d = cnt_q + ThreshW'(1);
          end else begin
            cnt_d  = '0;
            dial_d = key_q;
            ev0_d  = ev_press;
            ev1_d  = ev_rel_key;
            n_ev_d = 2'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= KeyNone;
      found_q  <= 1'b0;
      masked_q <= 1'b0;
      prev_q   <= KeyNone;
      held_q   <= KeyNone;
      dial_q   <= KeyNone;
      cnt_q    <= '0;
      n_ev_q   <= '0;
    end else begin
      key_q    <= key_d;
      found_q  <= found_d;
      masked_q <= masked_d;
      prev_q   <= prev_d;
      held_q   <= held_d;
      dial_q   <= dial_d;
      cnt_q    <= cnt_d;
      n_ev_q   <= n_ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      samp_q  <= in_data_i.sample;
      kmask_q <= in_data_i.key_mask;
    end
    ev0_q <= ev0_d;
    ev1_q <= ev1_d;
  end

  // output register
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_ev0 || cmd_i.load_ev1) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ev0) begin
      out_data_o <= ev0_q;
    end else if (cmd_i.load_ev1) begin
      out_data_o <= ev1_q;
    end
  end

  assign stat_o.searched = (int'(entry_count_q) > TableDepth) ? CntW'(TableDepth)
                                                              : CntW'(entry_count_q);
  assign stat_o.mode     = mode_q;
  assign stat_o.n_ev     = n_ev_q;
  assign stat_o.out_free = out_free;

endmodule

`default_nettype wire

// ===== rtl/adc_ladder_key_debouncer.sv =====
// Top level of the ADC ladder key debouncer.
//
//   channel | direction | handshake             | beat
//   in      | input     | in_valid_i/in_stall_o | in_item_t: sample tick or table write
//   out     | output    | out_valid_o/out_stall_i | out_item_t: one press/release event
//   cfg     | input     | cfg_valid_i/cfg_ready_o | register index and data
//
// A sample does one table read per cycle on the single RAM read port, once for the
// decode walk and, in key mode, once for the mask walk, then update and event
// emission; with no slot searched it goes straight to update.
// A stalled output holds the emitting state; the next beat is taken as soon as the
// last event sits in the output register. Reset clears debounce state and returns
// config to its defaults; the table stays unwritten.
`default_nettype none

module adc_ladder_key_debouncer
  import aldk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  aldk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_cmd_i  (in_data_i.cmd),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  aldk_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/aldk_checker.sv =====
// Port-level checks of the ADC ladder key debouncer, bound to the top level.
`default_nettype none

module aldk_checker
  import aldk_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      in_cmd_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

  // one sample at a time: stall right after an accepted sample beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_cmd_i == CmdSample)) |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  // releases carry no sample
  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pressed) |-> (out_data_o.adc_value == '0))
    else $error("release event with nonzero adc value");

  // events only come out of work on an item
  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("event emitted while idle");

endmodule

bind adc_ladder_key_debouncer aldk_checker u_aldk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_cmd_i   (in_data_i.cmd),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== tb/adc_ladder_key_debouncer_test.sv =====
// Self-checking testbench for the ADC ladder key debouncer: predicted key events vs. DUT output.
`timescale 1ns / 1ps

module adc_ladder_key_debouncer_test;
  import aldk_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 60;
  localparam int SampleMax = (1 << SampleBits) - 1;

  // Mirrors the decoder and debounce state, queues the key events it predicts.
  class key_event_tracker;
    logic [SampleBits-1:0]  level_tab [TableDepth];
    logic [CodeW-1:0]       code_tab [TableDepth];
    logic [MaskW-1:0]       mask_tab [TableDepth];
    logic [KeyW-1:0]        last_decoded;
    logic [KeyW-1:0]        held;
    logic [KeyW-1:0]        dial_pos;
    logic [ThreshW-1:0]     persist_cnt;
    logic [EntryCountW-1:0] slots_used;
    logic                   dial_mode;
    logic [ThreshW-1:0]     persist_limit;
    logic [WindowW-1:0]     half_win;
    out_item_t              pending_events [$];
    int                     error_count;

    function new();
      for (int i = 0; i < TableDepth; i++) begin
        level_tab[i] = '0;
        code_tab[i] = '0;
        mask_tab[i] = '0;
      end
      last_decoded = KeyNone;
      held = KeyNone;
      dial_pos = KeyNone;
      persist_cnt = '0;
      slots_used = '0;
      dial_mode = ModeKeys;
      persist_limit = DebounceReset;
      half_win = WindowReset;
      error_count = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
      case (idx)
        CfgEntryCount:  slots_used = d[EntryCountW-1:0];
        CfgChannelMode: dial_mode = d[0];
        CfgDebounce:    persist_limit = d[ThreshW-1:0];
        CfgWindow:      half_win = d[WindowW-1:0];
        default: ;
      endcase
    endfunction

    function int searched();
      return (int'(slots_used) > TableDepth) ? TableDepth : int'(slots_used);
    endfunction

    function logic [KeyW-1:0] lookup(logic [SampleBits-1:0] s);
      int lo;
      int hi;
      for (int i = 0; i < searched(); i++) begin
        lo = int'(level_tab[i]) - int'(half_win);
        if (lo < 0) lo = 0;
        hi = int'(level_tab[i]) + int'(half_win);
        if (lo <= int'(s) && int'(s) <= hi) return {1'b0, code_tab[i]};
      end
      return KeyNone;
    endfunction

    function void post_event(logic [KeyW-1:0] key, logic press,
                             logic [SampleBits-1:0] adc, logic last);
      out_item_t ev;
      ev.key_code = key[CodeW-1:0];
      ev.pressed = press;
      ev.adc_value = adc;
      ev.last_of_run = last;
      pending_events.push_back(ev);
    endfunction

    function void note_item(in_item_t it);
      logic [KeyW-1:0] key;
      if (it.cmd == CmdWrite) begin
        level_tab[it.entry_index] = it.entry_level;
        code_tab[it.entry_index] = it.entry_code;
        mask_tab[it.entry_index] = it.entry_mask;
        return;
      end
      key = lookup(it.sample);
      if (dial_mode == ModeKeys) begin
        // drop the sample if the decoded key (or the held key on release) is masked
        for (int i = 0; i < searched(); i++) begin
          if ((mask_tab[i] & it.key_mask) != '0) begin
            if (key != KeyNone && {1'b0, code_tab[i]} == key) return;
            if (key == KeyNone && {1'b0, code_tab[i]} == held) return;
          end
        end
        if (last_decoded != key) persist_cnt = '0;
        if (key != held) begin
          if (persist_cnt < persist_limit) begin
            persist_cnt++;
          end else begin
            if (key != KeyNone) begin
              if (held != KeyNone) post_event(held, 1'b0, '0, 1'b0);
              post_event(key, 1'b1, it.sample, 1'b1);
            end else begin
              post_event(held, 1'b0, '0, 1'b1);
            end
            persist_cnt = '0;
            held = key;
          end
        end else begin
          persist_cnt = '0;
        end
        last_decoded = key;
      end else if (key != KeyNone && key != dial_pos) begin
        if (persist_cnt < persist_limit) begin
          persist_cnt++;
        end else begin
          post_event(key, 1'b1, it.sample, 1'b0);
          post_event(key, 1'b0, '0, 1'b1);
          persist_cnt = '0;
          dial_pos = key;
        end
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: key event %s mismatch: expected %h, actual %h", $time, field, want, got);
      error_count++;
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected key event: expected none, actual %h", $time, got);
        error_count++;
        return;
      end
      want = pending_events.pop_front();
      if (got.key_code !== want.key_code) report("key_code", want.key_code, got.key_code);
      if (got.pressed !== want.pressed) report("pressed", want.pressed, got.pressed);
      if (got.adc_value !== want.adc_value) report("adc_value", want.adc_value, got.adc_value);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  key_event_tracker tracker = new();
  int burst_left = 0;
  int gap = 0;
  int stall_left = 0;
  int stall_style = 0;
  int cycles = 0;

  adc_ladder_key_debouncer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: switch among stall styles, each kept for a random span.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ~out_stall;
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) tracker.check_event(out_data);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** adc_ladder_key_debouncer: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t tick(logic [SampleBits-1:0] s, logic [MaskW-1:0] km);
    in_item_t it;
    it.cmd = CmdSample;
    it.sample = s;
    it.key_mask = km;
    it.entry_index = IndexW'($urandom);
    it.entry_level = SampleBits'($urandom);
    it.entry_code = CodeW'($urandom);
    it.entry_mask = MaskW'($urandom);
    return it;
  endfunction

  function automatic in_item_t table_write(logic [IndexW-1:0] slot);
    in_item_t it;
    it.cmd = CmdWrite;
    it.sample = SampleBits'($urandom);
    it.key_mask = MaskW'($urandom);
    it.entry_index = slot;
    it.entry_level = SampleBits'($urandom);
    // small codes give duplicate keys across slots
    it.entry_code = ($urandom_range(0, 1) == 0) ? CodeW'($urandom) : CodeW'($urandom_range(0, 7));
    case ($urandom_range(0, 2))
      0: it.entry_mask = '0;
      1: it.entry_mask = MaskW'(1) << $urandom_range(0, MaskW - 1);
      default: it.entry_mask = MaskW'($urandom);
    endcase
    return it;
  endfunction

  function automatic logic [SampleBits-1:0] pick_sample();
    int n;
    int w;
    int lvl;
    int v;
    n = tracker.searched();
    w = int'(tracker.half_win);
    if (n == 0 || $urandom_range(0, 4) == 0) return SampleBits'($urandom);
    lvl = int'(tracker.level_tab[$urandom_range(0, n - 1)]);
    case ($urandom_range(0, 4))
      0: v = lvl - w;
      1: v = lvl + w;
      default: v = lvl + int'($urandom_range(0, 2 * w)) - w;
    endcase
    if (v < 0) v = 0;
    if (v > SampleMax) v = SampleMax;
    return SampleBits'(v);
  endfunction

  function automatic logic [MaskW-1:0] pick_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return '0;
    if (r < 92) return MaskW'(1) << $urandom_range(0, MaskW - 1);
    return MaskW'($urandom);
  endfunction

  // Sender: hold the beat until accepted, then maybe open a gap.
  task automatic push_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    tracker.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold input until every predicted event is out, then idle for the extra time given by the caller.
  task automatic settle(int extra);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_events.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.set_reg(idx, d);
  endtask

  task automatic apply_settings(int cnt, logic mode, int thr, int win);
    settle(DrainCycles);
    // upper data bits are don't-care for the narrow registers
    cfg_write(CfgEntryCount, {3'($urandom), 5'(cnt)});
    cfg_write(CfgChannelMode, {7'($urandom), mode});
    cfg_write(CfgDebounce, 8'(thr));
    cfg_write(CfgWindow, 8'(win));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int cnt, logic mode, int thr, int win, int count);
    int sent;
    int roll;
    int run_len;
    int limit;
    logic [SampleBits-1:0] s;
    logic [MaskW-1:0] km;
    apply_settings(cnt, mode, thr, win);
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
        settle(0);
      end else if (roll < 6) begin
        push_item(table_write(IndexW'($urandom)));
        sent++;
      end else if (roll < 16) begin
        push_item(tick(SampleBits'($urandom), MaskW'($urandom)));
        sent++;
      end else begin
        // hold one reading long enough to clear the debounce most of the time
        s = pick_sample();
        km = pick_mask();
        limit = int'(tracker.persist_limit);
        run_len = ($urandom_range(0, 9) < 7) ? limit + $urandom_range(1, 3)
                                             : $urandom_range(1, limit + 1);
        if (run_len > count - sent) run_len = count - sent;
        repeat (run_len) begin
          push_item(tick(s, km));
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_item_t it;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // nothing searched before any slot is enabled
    push_item(tick(12'd2048, 16'h0000));
    for (int i = 0; i < TableDepth; i++) begin
      it = table_write(IndexW'(i));
      if (i == 0) begin
        it.entry_level = '0;
        it.entry_code = '0;
        it.entry_mask = 16'h0001;
      end else if (i == TableDepth - 1) begin
        it.entry_level = SampleBits'(SampleMax);
        it.entry_code = '1;
        it.entry_mask = '1;
      end else begin
        it.entry_level = SampleBits'(i * 256 + 8);
        it.entry_code = CodeW'(i * 37);
        it.entry_mask = MaskW'(1) << i;
      end
      push_item(it);
    end

    apply_settings(TableDepth, ModeKeys, 0, 10);
    push_item(tick(12'd0, 16'h0000));
    push_item(tick(12'd4095, 16'h0000));
    push_item(tick(12'd4095, 16'h8000));
    push_item(tick(12'd128, 16'h0100));
    push_item(tick(12'd128, 16'h0000));
    push_item(tick(12'd265, 16'h0001));

    apply_settings(TableDepth, ModeDial, 0, 10);
    push_item(tick(12'd265, 16'h0000));
    push_item(tick(12'd270, 16'h0000));
    push_item(tick(12'd128, 16'h0000));
    push_item(tick(12'd4095, 16'hFFFF));

    run_phase(16, ModeKeys, 1, 10, 300);
    run_phase(5, ModeKeys, 3, 40, 300);
    run_phase(31, ModeKeys, 0, 255, 200);
    run_phase(16, ModeDial, 0, 10, 300);
    run_phase(8, ModeDial, 2, 0, 200);
    run_phase(16, ModeKeys, 255, 20, 400);
    run_phase(0, ModeKeys, 1, 10, 60);
    run_phase(12, ModeKeys, 2, 128, 150);
    settle(DrainCycles);

    if (tracker.error_count == 0) begin
      $display("** adc_ladder_key_debouncer: PASSED **");
    end else begin
      $display("** adc_ladder_key_debouncer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aldk_pkg.sv
rtl/aldk_ram.sv
rtl/aldk_ctrl.sv
rtl/aldk_dpath.sv
rtl/adc_ladder_key_debouncer.sv
rtl/aldk_checker.sv
tb/adc_ladder_key_debouncer_test.sv
